// ===== hdl/rrat_pkg.sv =====
// rrat_pkg: shared types, widths, codes and default sizes for the register alias table
// no dependencies; compiled first
`default_nettype none

package rrat_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_W    = 3;
    localparam int unsigned TAG_W    = 8;
    localparam int unsigned VALUE_W  = 32;

    // default pool geometry (legal: 2..64 slots, base 0..192)
    localparam int unsigned POOL_ENTRIES_DEF = 64;
    localparam int unsigned TAG_BASE_DEF     = 0;

    // operation codes
    localparam logic OP_RENAME    = 1'b0;
    localparam logic OP_WRITEBACK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [REG_W-1:0]   arch_reg;
        logic [TAG_W-1:0]   wb_tag;
        logic [VALUE_W-1:0] wb_value;
    } req_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]   alloc_tag;
        logic               alloc_fail;
        logic               wb_hit;
        logic               free_error;
        logic               reg_valid;
        logic               reg_has_tag;
        logic [TAG_W-1:0]   reg_tag;
        logic [VALUE_W-1:0] reg_value;
    } rsp_item_t;

    // commands into the free list, applied at the clock edge
    typedef struct packed {
        logic alloc_en;
        logic free_en;
    } fl_cmd_t;

    // free list status for the current lookup
    typedef struct packed {
        logic found;
        logic slot_busy;
    } fl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rrat_req_if.sv =====
// rrat_req_if: valid/ready request channel carrying rename and writeback items
// depends on rrat_pkg
`default_nettype none

interface rrat_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [rrat_pkg::REG_W-1:0]    arch_reg;
    logic [rrat_pkg::TAG_W-1:0]    wb_tag;
    logic [rrat_pkg::VALUE_W-1:0]  wb_value;

    modport source (output valid, output operation, output arch_reg, output wb_tag,
                    output wb_value, input ready);
    modport sink   (input valid, input operation, input arch_reg, input wb_tag,
                    input wb_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrat_rsp_if.sv =====
// rrat_rsp_if: valid/ready result channel of the register alias table
// depends on rrat_pkg
`default_nettype none

interface rrat_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rrat_pkg::TAG_W-1:0]    alloc_tag;
    logic                          alloc_fail;
    logic                          wb_hit;
    logic                          free_error;
    logic                          reg_valid;
    logic                          reg_has_tag;
    logic [rrat_pkg::TAG_W-1:0]    reg_tag;
    logic [rrat_pkg::VALUE_W-1:0]  reg_value;

    modport source (output valid, output alloc_tag, output alloc_fail, output wb_hit,
                    output free_error, output reg_valid, output reg_has_tag,
                    output reg_tag, output reg_value, input ready);
    modport sink   (input valid, input alloc_tag, input alloc_fail, input wb_hit,
                    input free_error, input reg_valid, input reg_has_tag,
                    input reg_tag, input reg_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/register_rename_alias_table.sv =====
// register_rename_alias_table: top level of the register alias table and tag free list
// depends on rrat_pkg, rrat_req_if, rrat_rsp_if, rrat_free_list
//
// usage
//   req channel: one item per transfer. operation selects rename (take the
//     lowest free pool slot, tag = TAG_BASE + slot, store it in the arch_reg
//     entry and mark that entry pending) or writeback (wb_tag in range, held
//     by some entry and its slot busy: free the slot, write wb_value to
//     arch_reg and make that entry valid with no tag)
//   rsp channel: exactly one result per request, in order, with the status
//     flags and the arch_reg entry as it stands after the item
//   path: an item accepted from req sits in the input register, is processed
//     into the result register once that register is free, and its result
//     is then offered on rsp until taken
//   throughput: one item per cycle while rsp is not held off; the whole lookup
//     (POOL_ENTRIES-slot priority encoder, eight tag compares, entry update) is
//     one register-to-register pass; table state is written as the result loads
//   stall: while rsp is held off the result stays put and one more item may
//     wait in the input register; req.ready drops only when both are full
//   reset: rst_n low clears all slots to free, all entries to not valid with
//     no tag and value zero, and empties both registers
`default_nettype none

module register_rename_alias_table #(
    parameter int unsigned POOL_ENTRIES = rrat_pkg::POOL_ENTRIES_DEF,
    parameter int unsigned TAG_BASE     = rrat_pkg::TAG_BASE_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrat_req_if.sink    req,
    rrat_rsp_if.source  rsp
);
    import rrat_pkg::*;

    localparam int unsigned SLOT_W    = $clog2(POOL_ENTRIES);
    localparam int unsigned TAG_EXT_W = TAG_W + 1;

    // input register
    logic      in_valid_reg;
    req_item_t in_item_reg;

    // result register
    logic      out_valid_reg;
    rsp_item_t out_item_reg;
    rsp_item_t out_item_next;

    // table entries
    logic [NUM_REGS-1:0]    entry_valid_reg;
    logic [NUM_REGS-1:0]    entry_has_tag_reg;
    logic [TAG_W-1:0]       entry_tag_reg   [NUM_REGS];
    logic [VALUE_W-1:0]     entry_value_reg [NUM_REGS];

    // next contents of the named entry
    logic                   entry_wr;
    logic                   entry_valid_next;
    logic                   entry_has_tag_next;
    logic [TAG_W-1:0]       entry_tag_next;
    logic [VALUE_W-1:0]     entry_value_next;

    logic                   move;
    logic                   is_rename;
    logic                   in_range;
    logic                   held;
    logic                   hit;
    logic [TAG_W-1:0]       rel_tag;
    logic [TAG_W-1:0]       alloc_tag_calc;
    logic [SLOT_W-1:0]      free_slot;
    logic [SLOT_W-1:0]      alloc_slot;
    logic [REG_W-1:0]       sel;

    fl_cmd_t                fl_cmd;
    fl_stat_t               fl_stat;

    // the item in the input register moves on when the result register is free
    assign move      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || move;

    assign sel       = in_item_reg.arch_reg;
    assign is_rename = (in_item_reg.operation == OP_RENAME);

    // writeback tag range check and slot index
    assign in_range = ({1'b0, in_item_reg.wb_tag} >= TAG_EXT_W'(TAG_BASE))
                   && ({1'b0, in_item_reg.wb_tag} <  TAG_EXT_W'(TAG_BASE + POOL_ENTRIES));
    assign rel_tag   = in_item_reg.wb_tag - TAG_W'(TAG_BASE);
    assign free_slot = rel_tag[SLOT_W-1:0];

    // does any entry hold the tag
    always_comb
    begin
        held = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (entry_has_tag_reg[i] && entry_tag_reg[i] == in_item_reg.wb_tag)
            begin
                held = 1'b1;
            end
        end
    end

    assign hit            = !is_rename && in_range && held && fl_stat.slot_busy;
    assign alloc_tag_calc = TAG_W'(TAG_BASE) + TAG_W'(alloc_slot);

    // alloc_en, free_en
    assign fl_cmd = {move && is_rename && fl_stat.found, move && hit};

    rrat_free_list #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .SLOT_W       (SLOT_W)
    ) u_free_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (fl_cmd),
        .free_slot  (free_slot),
        .stat       (fl_stat),
        .alloc_slot (alloc_slot)
    );

    // entry update and result for the item in the input register
    always_comb
    begin
        entry_wr           = 1'b0;
        entry_valid_next   = entry_valid_reg[sel];
        entry_has_tag_next = entry_has_tag_reg[sel];
        entry_tag_next     = entry_tag_reg[sel];
        entry_value_next   = entry_value_reg[sel];
        out_item_next      = '0;

        if (is_rename)
        begin
            // pool empty leaves the entry pending with no tag
            entry_wr           = 1'b1;
            entry_valid_next   = 1'b0;
            entry_has_tag_next = fl_stat.found;
            entry_tag_next     = fl_stat.found ? alloc_tag_calc : '0;
            out_item_next.alloc_tag  = fl_stat.found ? alloc_tag_calc : '0;
            out_item_next.alloc_fail = !fl_stat.found;
        end
        else
        begin
            if (hit)
            begin
                entry_wr           = 1'b1;
                entry_valid_next   = 1'b1;
                entry_has_tag_next = 1'b0;
                entry_tag_next     = '0;
                entry_value_next   = in_item_reg.wb_value;
            end
            out_item_next.wb_hit     = hit;
            out_item_next.free_error = in_range && held && !fl_stat.slot_busy;
        end

        out_item_next.reg_valid   = entry_valid_next;
        out_item_next.reg_has_tag = entry_has_tag_next;
        out_item_next.reg_tag     = entry_has_tag_next ? entry_tag_next : '0;
        out_item_next.reg_value   = entry_value_next;
    end

    // handshake registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg.operation <= req.operation;
            in_item_reg.arch_reg  <= req.arch_reg;
            in_item_reg.wb_tag    <= req.wb_tag;
            in_item_reg.wb_value  <= req.wb_value;
        end
        if (move)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // alias table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg   <= '0;
            entry_has_tag_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                entry_tag_reg[i]   <= '0;
                entry_value_reg[i] <= '0;
            end
        end
        else if (move && entry_wr)
        begin
            entry_valid_reg[sel]   <= entry_valid_next;
            entry_has_tag_reg[sel] <= entry_has_tag_next;
            entry_tag_reg[sel]     <= entry_tag_next;
            entry_value_reg[sel]   <= entry_value_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.alloc_tag   = out_item_reg.alloc_tag;
    assign rsp.alloc_fail  = out_item_reg.alloc_fail;
    assign rsp.wb_hit      = out_item_reg.wb_hit;
    assign rsp.free_error  = out_item_reg.free_error;
    assign rsp.reg_valid   = out_item_reg.reg_valid;
    assign rsp.reg_has_tag = out_item_reg.reg_has_tag;
    assign rsp.reg_tag     = out_item_reg.reg_tag;
    assign rsp.reg_value   = out_item_reg.reg_value;

endmodule

`default_nettype wire

// ===== hdl/rrat_free_list.sv =====
// rrat_free_list: in-use bit per pool slot, lowest-free-slot encoder, busy lookup
// depends on rrat_pkg
`default_nettype none

module rrat_free_list #(
    parameter int unsigned POOL_ENTRIES = rrat_pkg::POOL_ENTRIES_DEF,
    parameter int unsigned SLOT_W       = $clog2(POOL_ENTRIES)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rrat_pkg::fl_cmd_t   cmd,
    input  wire logic [SLOT_W-1:0]   free_slot,
    output rrat_pkg::fl_stat_t       stat,
    output logic [SLOT_W-1:0]        alloc_slot
);
    import rrat_pkg::*;

    logic [POOL_ENTRIES-1:0] slot_in_use_reg;
    logic [POOL_ENTRIES-1:0] slot_in_use_next;

    // lowest free slot wins; busy lookup, codes past the pool read as free
    always_comb
    begin
        stat.found     = 1'b0;
        stat.slot_busy = 1'b0;
        alloc_slot     = '0;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--)
        begin
            if (!slot_in_use_reg[i])
            begin
                stat.found = 1'b1;
                alloc_slot = SLOT_W'(i);
            end
        end
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            if (free_slot == SLOT_W'(i))
            begin
                stat.slot_busy = slot_in_use_reg[i];
            end
        end
    end

    always_comb
    begin
        slot_in_use_next = slot_in_use_reg;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            if (cmd.alloc_en && alloc_slot == SLOT_W'(i))
            begin
                slot_in_use_next[i] = 1'b1;
            end
            if (cmd.free_en && free_slot == SLOT_W'(i))
            begin
                slot_in_use_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_in_use_reg <= '0;
        end
        else
        begin
            slot_in_use_reg <= slot_in_use_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rrat_checker.sv =====
// rrat_checker: port-level checks of the register alias table, bound to the top level
// depends on rrat_pkg and register_rename_alias_table
`default_nettype none

module rrat_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [rrat_pkg::TAG_W-1:0]    alloc_tag,
    input wire logic                          alloc_fail,
    input wire logic                          wb_hit,
    input wire logic                          free_error,
    input wire logic                          reg_valid,
    input wire logic                          reg_has_tag,
    input wire logic [rrat_pkg::TAG_W-1:0]    reg_tag
);
    import rrat_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a result appearing in an empty output follows an earlier request transfer
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching request");

    // failed rename gives no tag and leaves the entry pending with no tag
    a_fail_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alloc_fail |->
            alloc_tag == '0 && !reg_valid && !reg_has_tag && reg_tag == '0)
        else $error("bad entry after failed rename");

    // applied writeback leaves the entry valid with no tag
    a_hit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wb_hit |-> reg_valid && !reg_has_tag && reg_tag == '0)
        else $error("bad entry after writeback");

    // status flags are mutually exclusive
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({alloc_fail, wb_hit, free_error}) <= 1)
        else $error("conflicting status flags");

endmodule

bind register_rename_alias_table rrat_checker u_rrat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .alloc_tag   (rsp.alloc_tag),
    .alloc_fail  (rsp.alloc_fail),
    .wb_hit      (rsp.wb_hit),
    .free_error  (rsp.free_error),
    .reg_valid   (rsp.reg_valid),
    .reg_has_tag (rsp.reg_has_tag),
    .reg_tag     (rsp.reg_tag)
);

`default_nettype wire
